// ===== src/bcdse_pkg.sv =====
// ----------------------------------------------------------------------------
// bcdse_pkg
// Shared widths, codes and BCD limits of the clock setting editor.
// ----------------------------------------------------------------------------
package bcdse_pkg;

    localparam int REQ_W   = 2;
    localparam int KEY_W   = 4;
    localparam int SEL_W   = 3;
    localparam int FIELD_W = 8;
    localparam int PTR_W   = 3;
    localparam int MODE_W  = 2;
    localparam int SNAP_N  = 7;
    localparam int SNAP_W  = SNAP_N * FIELD_W;

    localparam int DEF_NUM_FIELDS = 7;
    localparam int DEF_NUM_MODES  = 4;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_KEY        = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_TIME  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOAD_ALARM = 2'd2;

    // Key codes.
    localparam logic [KEY_W-1:0] KEY_SET   = 4'd1;
    localparam logic [KEY_W-1:0] KEY_UP    = 4'd2;
    localparam logic [KEY_W-1:0] KEY_DOWN  = 4'd3;
    localparam logic [KEY_W-1:0] KEY_NEXT  = 4'd4;
    localparam logic [KEY_W-1:0] KEY_MODE  = 4'd5;
    localparam logic [KEY_W-1:0] KEY_ALARM = 4'd6;
    localparam logic [KEY_W-1:0] KEY_AUX7  = 4'd7;
    localparam logic [KEY_W-1:0] KEY_AUX8  = 4'd8;
    localparam logic [KEY_W-1:0] KEY_AUX9  = 4'd9;

    // Field indexes.
    localparam logic [PTR_W-1:0] FLD_SEC   = 3'd0;
    localparam logic [PTR_W-1:0] FLD_MIN   = 3'd1;
    localparam logic [PTR_W-1:0] FLD_HOUR  = 3'd2;
    localparam logic [PTR_W-1:0] FLD_DAY   = 3'd3;
    localparam logic [PTR_W-1:0] FLD_MONTH = 3'd4;
    localparam logic [PTR_W-1:0] FLD_WDAY  = 3'd5;
    localparam logic [PTR_W-1:0] FLD_YEAR  = 3'd6;

    // BCD limits.
    localparam logic [FIELD_W-1:0] BCD_ZERO     = 8'h00;
    localparam logic [FIELD_W-1:0] BCD_ONE      = 8'h01;
    localparam logic [FIELD_W-1:0] BCD_SIXTY    = 8'h60;
    localparam logic [FIELD_W-1:0] BCD_MAX_MIN  = 8'h59;
    localparam logic [FIELD_W-1:0] BCD_HOURS    = 8'h24;
    localparam logic [FIELD_W-1:0] BCD_MAX_HOUR = 8'h23;
    localparam logic [FIELD_W-1:0] BCD_DAYS     = 8'h32;
    localparam logic [FIELD_W-1:0] BCD_MAX_DAY  = 8'h31;
    localparam logic [FIELD_W-1:0] BCD_MONTHS   = 8'h13;
    localparam logic [FIELD_W-1:0] BCD_MAX_MON  = 8'h12;
    localparam logic [FIELD_W-1:0] BCD_WDAYS    = 8'h08;
    localparam logic [FIELD_W-1:0] BCD_MAX_WDAY = 8'h07;
    localparam logic [FIELD_W-1:0] BCD_YEARS    = 8'hA0;
    localparam logic [FIELD_W-1:0] BCD_MAX_YEAR = 8'h99;
    localparam logic [3:0]         BCD_DIGIT_MAX = 4'd9;
    localparam logic [FIELD_W-1:0] BCD_ADJ      = 8'h06;

    // Register indexes.
    localparam logic REG_HOME_MODE  = 1'b0;
    localparam logic REG_ALARM_MODE = 1'b1;

    localparam logic [MODE_W-1:0] HOME_MODE_RST  = 2'd0;
    localparam logic [MODE_W-1:0] ALARM_MODE_RST = 2'd2;

endpackage

// ===== src/bcdse_in_if.sv =====
// ----------------------------------------------------------------------------
// bcdse_in_if
// Request channel: key presses and field loads, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bcdse_in_if import bcdse_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [KEY_W-1:0]   key_code;
    logic [SEL_W-1:0]   field_select;
    logic [FIELD_W-1:0] field_value;

    modport source (output valid, req_type, key_code, field_select, field_value,
                    input ready);
    modport sink   (input valid, req_type, key_code, field_select, field_value,
                    output ready);
endinterface

// ===== src/bcdse_out_if.sv =====
// ----------------------------------------------------------------------------
// bcdse_out_if
// Result channel: editor status after each request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bcdse_out_if import bcdse_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               led_on;
    logic               time_set_active;
    logic               alarm_set_active;
    logic [PTR_W-1:0]   field_pointer;
    logic [MODE_W-1:0]  display_mode;
    logic               commit_pulse;
    logic               clear_screen_pulse;
    logic               alarm_marker_write;
    logic [FIELD_W-1:0] edited_value;
    logic [SNAP_W-1:0]  time_snapshot;

    modport source (output valid, led_on, time_set_active, alarm_set_active,
                    field_pointer, display_mode, commit_pulse, clear_screen_pulse,
                    alarm_marker_write, edited_value, time_snapshot,
                    input ready);
    modport sink   (input valid, led_on, time_set_active, alarm_set_active,
                    field_pointer, display_mode, commit_pulse, clear_screen_pulse,
                    alarm_marker_write, edited_value, time_snapshot,
                    output ready);
endinterface

// ===== src/bcd_clock_setting_editor_core.sv =====
// ----------------------------------------------------------------------------
// bcd_clock_setting_editor_core
// Key-driven editor for BCD time and alarm fields with an APB register port.
//
//   channel   dir   handshake       word
//   i_req     in    valid/ready     req_type, key_code, field_select, field_value
//   o_res     out   valid/ready     led_on .. edited_value, time_snapshot
//   apb       in    psel/penable    home_display_mode, alarm_display_mode
//
// Each request word is decoded and applied to the field and mode registers in
// the cycle it is accepted; its result word sits in the output register on the
// next cycle. One word per cycle is taken as long as the output register is
// empty or is being drained in the same cycle. Reset is synchronous and clears
// all fields, flags and the output valid.
// ----------------------------------------------------------------------------
module bcd_clock_setting_editor_core import bcdse_pkg::*; #(
    parameter int NUM_FIELDS = DEF_NUM_FIELDS,
    parameter int NUM_MODES  = DEF_NUM_MODES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcdse_in_if.sink    i_req,
    bcdse_out_if.source o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W   = $clog2(NUM_FIELDS);
    localparam int SHOWN_N = (NUM_FIELDS < SNAP_N) ? NUM_FIELDS : SNAP_N;
    localparam logic [PTR_W:0]  NF_LIM = (PTR_W + 1)'(NUM_FIELDS);
    localparam logic [MODE_W:0] NM_LIM = (MODE_W + 1)'(NUM_MODES);

    logic [MODE_W-1:0]  r_home_mode;
    logic [MODE_W-1:0]  r_alarm_mode;

    logic               r_led,       n_led;
    logic               r_time_set,  n_time_set;
    logic               r_alarm_set, n_alarm_set;
    logic [PTR_W-1:0]   r_ptr,       n_ptr;
    logic [MODE_W-1:0]  r_mode,      n_mode;
    logic [FIELD_W-1:0] r_time  [NUM_FIELDS];
    logic [FIELD_W-1:0] n_time  [NUM_FIELDS];
    logic [FIELD_W-1:0] r_alarm [NUM_FIELDS];
    logic [FIELD_W-1:0] n_alarm [NUM_FIELDS];

    logic               r_out_valid;
    logic               r_commit, n_commit;
    logic               r_clear,  n_clear;
    logic               r_marker, n_marker;
    logic [FIELD_W-1:0] r_edited, n_edited;
    logic [SNAP_W-1:0]  r_snap,   n_snap;

    logic               accept;
    logic               cfg_write;
    logic [FIELD_W-1:0] step_cur;
    logic [FIELD_W-1:0] step_res;
    logic               step_up;
    logic [PTR_W:0]     ptr_inc;
    logic [MODE_W:0]    mode_inc;
    logic               sel_ok;
    logic [IDX_W-1:0]   cur_idx;
    logic [IDX_W-1:0]   nxt_idx;
    logic [IDX_W-1:0]   sel_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_ALARM_MODE) ? {30'd0, r_alarm_mode}
                                                    : {30'd0, r_home_mode};

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign cur_idx  = r_ptr[IDX_W-1:0];
    assign nxt_idx  = n_ptr[IDX_W-1:0];
    assign sel_idx  = i_req.field_select[IDX_W-1:0];
    assign step_cur = r_time_set ? r_time[cur_idx] : r_alarm[cur_idx];
    assign step_up  = (i_req.key_code == KEY_UP);
    assign ptr_inc  = {1'b0, r_ptr} + (PTR_W + 1)'(1);
    assign mode_inc = {1'b0, r_mode} + (MODE_W + 1)'(1);
    assign sel_ok   = ({1'b0, i_req.field_select} < NF_LIM);

    bcdse_bcd_step u_step (
        .i_value (step_cur),
        .i_field (r_ptr),
        .i_up    (step_up),
        .o_value (step_res)
    );

    always_comb begin
        n_led       = r_led;
        n_time_set  = r_time_set;
        n_alarm_set = r_alarm_set;
        n_ptr       = r_ptr;
        n_mode      = r_mode;
        n_time      = r_time;
        n_alarm     = r_alarm;
        n_commit    = 1'b0;
        n_clear     = 1'b0;
        n_marker    = 1'b0;
        case (i_req.req_type)
            REQ_LOAD_TIME: begin
                if (sel_ok) n_time[sel_idx] = i_req.field_value;
            end
            REQ_LOAD_ALARM: begin
                if (sel_ok) n_alarm[sel_idx] = i_req.field_value;
            end
            REQ_KEY: begin
                case (i_req.key_code)
                    KEY_SET: begin
                        n_led      = !r_led;
                        n_time_set = !r_time_set;
                        n_ptr      = '0;
                        n_commit   = 1'b1;
                    end
                    KEY_UP, KEY_DOWN: begin
                        n_led = !r_led;
                        if (r_time_set) begin
                            n_time[cur_idx] = step_res;
                        end else if (r_alarm_set) begin
                            n_alarm[cur_idx] = step_res;
                        end
                    end
                    KEY_NEXT: begin
                        n_led = !r_led;
                        n_ptr = (ptr_inc >= NF_LIM) ? '0 : ptr_inc[PTR_W-1:0];
                    end
                    KEY_MODE: begin
                        n_led   = !r_led;
                        n_clear = 1'b1;
                        n_mode  = (mode_inc >= NM_LIM) ? r_home_mode
                                                       : mode_inc[MODE_W-1:0];
                    end
                    KEY_ALARM: begin
                        // Outside the alarm page this key leaves the LED as it was.
                        if (r_mode == r_alarm_mode) begin
                            n_led       = !r_led;
                            n_alarm_set = !r_alarm_set;
                            n_ptr       = '0;
                            n_marker    = 1'b1;
                        end
                    end
                    KEY_AUX7, KEY_AUX8, KEY_AUX9: begin
                        n_led = !r_led;
                    end
                    default: begin
                        n_led = r_led;
                    end
                endcase
            end
            default: begin
                n_led = r_led;
            end
        endcase
        n_edited = n_alarm_set ? n_alarm[nxt_idx] : n_time[nxt_idx];
    end

    for (genvar g = 0; g < SHOWN_N; g++) begin : g_snap
        assign n_snap[g*FIELD_W +: FIELD_W] = n_time[g];
    end
    if (SHOWN_N < SNAP_N) begin : g_snap_pad
        assign n_snap[SNAP_W-1:SHOWN_N*FIELD_W] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home_mode  <= HOME_MODE_RST;
            r_alarm_mode <= ALARM_MODE_RST;
            r_led        <= 1'b0;
            r_time_set   <= 1'b0;
            r_alarm_set  <= 1'b0;
            r_ptr        <= '0;
            r_mode       <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                r_time[i]  <= '0;
                r_alarm[i] <= '0;
            end
        end else begin
            if (cfg_write) begin
                if (paddr[2] == REG_ALARM_MODE) begin
                    r_alarm_mode <= pwdata[MODE_W-1:0];
                end else begin
                    r_home_mode <= pwdata[MODE_W-1:0];
                end
            end
            if (accept) begin
                r_led       <= n_led;
                r_time_set  <= n_time_set;
                r_alarm_set <= n_alarm_set;
                r_ptr       <= n_ptr;
                r_mode      <= n_mode;
                r_time      <= n_time;
                r_alarm     <= n_alarm;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word register; no reset needed behind the valid flag.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_commit <= n_commit;
            r_clear  <= n_clear;
            r_marker <= n_marker;
            r_edited <= n_edited;
            r_snap   <= n_snap;
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.led_on             = r_led;
    assign o_res.time_set_active    = r_time_set;
    assign o_res.alarm_set_active   = r_alarm_set;
    assign o_res.field_pointer      = r_ptr;
    assign o_res.display_mode       = r_mode;
    assign o_res.commit_pulse       = r_commit;
    assign o_res.clear_screen_pulse = r_clear;
    assign o_res.alarm_marker_write = r_marker;
    assign o_res.edited_value       = r_edited;
    assign o_res.time_snapshot      = r_snap;

endmodule

// ===== src/bcdse_bcd_step.sv =====
// ----------------------------------------------------------------------------
// bcdse_bcd_step
// One BCD increment or decrement of a clock field with the field's wrap.
// ----------------------------------------------------------------------------
module bcdse_bcd_step import bcdse_pkg::*; (
    input  logic [FIELD_W-1:0] i_value,
    input  logic [PTR_W-1:0]   i_field,
    input  logic               i_up,
    output logic [FIELD_W-1:0] o_value
);

    logic [FIELD_W-1:0] raw;
    logic [FIELD_W-1:0] adj;

    always_comb begin
        raw = i_up ? i_value + 8'd1 : i_value - 8'd1;
        adj = raw;
        if (raw[3:0] > BCD_DIGIT_MAX) begin
            adj = i_up ? raw + BCD_ADJ : raw - BCD_ADJ;
        end
        o_value = adj;
        case (i_field)
            FLD_SEC, FLD_MIN: begin
                if (adj >= BCD_SIXTY) o_value = i_up ? BCD_ZERO : BCD_MAX_MIN;
            end
            FLD_HOUR: begin
                if (adj >= BCD_HOURS) o_value = i_up ? BCD_ZERO : BCD_MAX_HOUR;
            end
            FLD_DAY: begin
                if (i_up) begin
                    if (adj >= BCD_DAYS) o_value = BCD_ONE;
                end else if (adj >= BCD_DAYS || adj == BCD_ZERO) begin
                    o_value = BCD_MAX_DAY;
                end
            end
            FLD_MONTH: begin
                if (i_up) begin
                    if (adj >= BCD_MONTHS) o_value = BCD_ONE;
                end else if (adj >= BCD_MONTHS || adj == BCD_ZERO) begin
                    o_value = BCD_MAX_MON;
                end
            end
            FLD_WDAY: begin
                if (i_up) begin
                    if (adj >= BCD_WDAYS) o_value = BCD_ONE;
                end else if (adj >= BCD_WDAYS || adj == BCD_ZERO) begin
                    o_value = BCD_MAX_WDAY;
                end
            end
            FLD_YEAR: begin
                if (adj >= BCD_YEARS) o_value = i_up ? BCD_ZERO : BCD_MAX_YEAR;
            end
            default: begin
                // An eighth field has no calendar limit and wraps at 8 bits.
                o_value = adj;
            end
        endcase
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the BCD clock setting editor. A short directed walk
// covers seconds, day and year wraps, all keys bar the auxiliary ones and the
// ignored requests. Random phases of key presses and field loads follow, each
// under its own pair of display modes. Every result word is checked against
// an in-bench editor model; both channels idle at random in all but one phase.
// ----------------------------------------------------------------------------
module tb;
    import bcdse_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_NONE   = 4'd0;
    localparam logic [KEY_W-1:0] KEY_LAST   = 4'd15;
    localparam logic [SEL_W-1:0] SEL_NONE   = 3'd7;
    localparam logic [2:0] ADDR_HOME  = {REG_HOME_MODE, 2'b00};
    localparam logic [2:0] ADDR_ALARM = {REG_ALARM_MODE, 2'b00};

    localparam int NUM_FLDS    = DEF_NUM_FIELDS;
    localparam int NUM_PAGES   = DEF_NUM_MODES;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_WORDS = 250;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic               led;
        logic               tset;
        logic               aset;
        logic [PTR_W-1:0]   ptr;
        logic [MODE_W-1:0]  page;
        logic               commit;
        logic               clr;
        logic               marker;
        logic [FIELD_W-1:0] ev;
        logic [SNAP_W-1:0]  snap;
    } t_status;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [KEY_W-1:0]   key;
        logic [SEL_W-1:0]   sel;
        logic [FIELD_W-1:0] val;
    } t_word;

    typedef struct {
        t_word   w;
        bit      typed;
        t_status exp;
    } t_stim_row;

    localparam t_status NO_EXP = '0;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bcdse_in_if  req_if ();
    bcdse_out_if res_if ();

    bcd_clock_setting_editor_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Model of the editor state and its two mode registers.
    logic               led_q;
    logic               tset_q;
    logic               aset_q;
    logic [PTR_W-1:0]   ptr_q;
    logic [MODE_W-1:0]  page_q;
    logic [MODE_W-1:0]  home_page;
    logic [MODE_W-1:0]  alarm_page;
    logic [FIELD_W-1:0] clock_f [NUM_FLDS];
    logic [FIELD_W-1:0] wake_f  [NUM_FLDS];

    t_status   status_q [$];
    t_stim_row stim_tab [$];

    int  cycles;
    int  errors;
    int  checked;
    int  key_cnt;
    int  load_cnt;
    int  cfg_cnt;
    bit  tx_idle;
    bit  rx_idle;
    bit  hold_ask;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [FIELD_W-1:0] bcd_inc(input logic [FIELD_W-1:0] v,
                                                   input logic [PTR_W-1:0] f);
        logic [FIELD_W-1:0] n;
        n = v + BCD_ONE;
        if (n[3:0] > BCD_DIGIT_MAX) n = n + BCD_ADJ;
        case (f)
            FLD_SEC, FLD_MIN: if (n >= BCD_SIXTY) n = BCD_ZERO;
            FLD_HOUR:         if (n >= BCD_HOURS) n = BCD_ZERO;
            FLD_DAY:          if (n >= BCD_DAYS) n = BCD_ONE;
            FLD_MONTH:        if (n >= BCD_MONTHS) n = BCD_ONE;
            FLD_WDAY:         if (n >= BCD_WDAYS) n = BCD_ONE;
            FLD_YEAR:         if (n >= BCD_YEARS) n = BCD_ZERO;
            default: ;
        endcase
        return n;
    endfunction

    function automatic logic [FIELD_W-1:0] bcd_dec(input logic [FIELD_W-1:0] v,
                                                   input logic [PTR_W-1:0] f);
        logic [FIELD_W-1:0] n;
        n = v - BCD_ONE;
        if (n[3:0] > BCD_DIGIT_MAX) n = n - BCD_ADJ;
        case (f)
            FLD_SEC, FLD_MIN: if (n >= BCD_SIXTY) n = BCD_MAX_MIN;
            FLD_HOUR:         if (n >= BCD_HOURS) n = BCD_MAX_HOUR;
            FLD_DAY:   if (n >= BCD_DAYS || n == BCD_ZERO) n = BCD_MAX_DAY;
            FLD_MONTH: if (n >= BCD_MONTHS || n == BCD_ZERO) n = BCD_MAX_MON;
            FLD_WDAY:  if (n >= BCD_WDAYS || n == BCD_ZERO) n = BCD_MAX_WDAY;
            FLD_YEAR:         if (n >= BCD_YEARS) n = BCD_MAX_YEAR;
            default: ;
        endcase
        return n;
    endfunction

    // Applies one accepted word to the model and returns the status it shows.
    function automatic t_status predict_status(input t_word w);
        t_status s;
        s = '0;
        case (w.req)
            REQ_LOAD_TIME:  if (w.sel < NUM_FLDS) clock_f[w.sel] = w.val;
            REQ_LOAD_ALARM: if (w.sel < NUM_FLDS) wake_f[w.sel] = w.val;
            REQ_KEY: begin
                case (w.key)
                    KEY_SET: begin
                        led_q    = ~led_q;
                        tset_q   = ~tset_q;
                        ptr_q    = FLD_SEC;
                        s.commit = 1'b1;
                    end
                    KEY_UP, KEY_DOWN: begin
                        led_q = ~led_q;
                        // Time editing wins over alarm editing when both are on.
                        if (tset_q) begin
                            clock_f[ptr_q] = (w.key == KEY_UP) ? bcd_inc(clock_f[ptr_q], ptr_q)
                                                               : bcd_dec(clock_f[ptr_q], ptr_q);
                        end else if (aset_q) begin
                            wake_f[ptr_q] = (w.key == KEY_UP) ? bcd_inc(wake_f[ptr_q], ptr_q)
                                                              : bcd_dec(wake_f[ptr_q], ptr_q);
                        end
                    end
                    KEY_NEXT: begin
                        led_q = ~led_q;
                        ptr_q = (int'(ptr_q) + 1 >= NUM_FLDS) ? FLD_SEC : ptr_q + 1'b1;
                    end
                    KEY_MODE: begin
                        led_q  = ~led_q;
                        s.clr  = 1'b1;
                        page_q = (int'(page_q) + 1 >= NUM_PAGES) ? home_page : page_q + 1'b1;
                    end
                    KEY_ALARM: begin
                        if (page_q == alarm_page) begin
                            led_q    = ~led_q;
                            aset_q   = ~aset_q;
                            ptr_q    = FLD_SEC;
                            s.marker = 1'b1;
                        end
                    end
                    KEY_AUX7, KEY_AUX8, KEY_AUX9: led_q = ~led_q;
                    default: ;
                endcase
            end
            default: ;
        endcase
        s.led  = led_q;
        s.tset = tset_q;
        s.aset = aset_q;
        s.ptr  = ptr_q;
        s.page = page_q;
        s.ev   = aset_q ? wake_f[ptr_q] : clock_f[ptr_q];
        for (int i = 0; i < SNAP_N; i++) s.snap[i*FIELD_W +: FIELD_W] = clock_f[i];
        return s;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly a legal BCD value for the field, now and then any byte.
    function automatic logic [FIELD_W-1:0] field_bcd(input logic [SEL_W-1:0] f);
        logic [FIELD_W-1:0] lim;
        logic [FIELD_W-1:0] v;
        bit                 from_one;
        if ($urandom_range(0, 7) == 0) return FIELD_W'($urandom_range(0, 255));
        from_one = (f == FLD_DAY || f == FLD_MONTH || f == FLD_WDAY);
        case (f)
            FLD_SEC, FLD_MIN: lim = BCD_SIXTY;
            FLD_HOUR:         lim = BCD_HOURS;
            FLD_DAY:          lim = BCD_DAYS;
            FLD_MONTH:        lim = BCD_MONTHS;
            FLD_WDAY:         lim = BCD_WDAYS;
            default:          lim = BCD_YEARS;
        endcase
        do begin
            v = FIELD_W'($urandom_range(0, lim - 1));
        end while (v[3:0] > BCD_DIGIT_MAX || (from_one && v == BCD_ZERO));
        return v;
    endfunction

    function automatic t_word random_word();
        t_word w;
        int    r;
        w.req = REQ_KEY;
        w.key = KEY_W'($urandom_range(0, KEY_LAST));
        w.sel = SEL_W'($urandom_range(0, SEL_NONE));
        w.val = FIELD_W'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 30) begin
            w.req = (r < 22) ? REQ_LOAD_TIME : REQ_LOAD_ALARM;
            w.sel = ($urandom_range(0, 19) == 0) ? SEL_NONE
                                                 : SEL_W'($urandom_range(FLD_SEC, FLD_YEAR));
            w.val = field_bcd(w.sel);
        end else if (r < 45) begin
            w.key = KEY_UP;
        end else if (r < 57) begin
            w.key = KEY_DOWN;
        end else if (r < 67) begin
            w.key = KEY_NEXT;
        end else if (r < 74) begin
            w.key = KEY_SET;
        end else if (r < 83) begin
            w.key = KEY_MODE;
        end else if (r < 92) begin
            w.key = KEY_ALARM;
        end else if (r < 96) begin
            w.key = KEY_W'($urandom_range(KEY_AUX7, KEY_AUX9));
        end else if (r < 97) begin
            w.req = REQ_UNUSED;
        end else if (r < 98) begin
            w.key = KEY_NONE;
        end else begin
            w.key = KEY_W'($urandom_range(KEY_AUX9 + 1, KEY_LAST));
        end
        return w;
    endfunction

    function automatic t_status quiet_status(input logic [FIELD_W-1:0] ev,
                                             input logic [SNAP_W-1:0] snap);
        t_status s;
        s      = '0;
        s.ev   = ev;
        s.snap = snap;
        return s;
    endfunction

    task automatic add_row(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                           input logic [SEL_W-1:0] sel, input logic [FIELD_W-1:0] val,
                           input bit typed, input t_status exp);
        t_stim_row row;
        row.w     = {req, key, sel, val};
        row.typed = typed;
        row.exp   = exp;
        stim_tab.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input t_word w, input bit typed, input t_status typed_exp);
        int      gap;
        t_status s;
        gap = tx_idle ? idle_len() : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= w.req;
        req_if.key_code     <= w.key;
        req_if.field_select <= w.sel;
        req_if.field_value  <= w.val;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        s = predict_status(w);
        status_q.push_back(typed ? typed_exp : s);
        if (w.req == REQ_KEY) key_cnt++;
        else if (w.req != REQ_UNUSED) load_cnt++;
        @(negedge i_clk);
    endtask

    // Holds the request channel until every expected word has come back.
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [MODE_W-1:0] mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(mode);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_HOME) home_page = mode;
        else alarm_page = mode;
        cfg_cnt++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : rx_drive
        int gap;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_ask) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_ask = 1'b0;
            end else begin
                gap = rx_idle ? idle_len() : 0;
                if (gap > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end else begin
                    res_if.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin : res_check
        t_status got;
        t_status want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = {res_if.led_on, res_if.time_set_active, res_if.alarm_set_active,
                   res_if.field_pointer, res_if.display_mode, res_if.commit_pulse,
                   res_if.clear_screen_pulse, res_if.alarm_marker_write,
                   res_if.edited_value, res_if.time_snapshot};
            checked++;
            if (status_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] result word with nothing expected", $realtime);
            end else begin
                want = status_q.pop_front();
                if (got.led !== want.led || got.tset !== want.tset || got.aset !== want.aset
                    || got.ptr !== want.ptr || got.page !== want.page
                    || got.commit !== want.commit || got.clr !== want.clr
                    || got.marker !== want.marker || got.ev !== want.ev
                    || got.snap !== want.snap) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display({"[%0t] exp led=%b ts=%b as=%b ptr=%0d mode=%0d",
                                  " cm=%b cl=%b mk=%b val=%h snap=%h"},
                                 $realtime, want.led, want.tset, want.aset, want.ptr,
                                 want.page, want.commit, want.clr, want.marker,
                                 want.ev, want.snap);
                        $display({"[%0t] got led=%b ts=%b as=%b ptr=%0d mode=%0d",
                                  " cm=%b cl=%b mk=%b val=%h snap=%h"},
                                 $realtime, got.led, got.tset, got.aset, got.ptr,
                                 got.page, got.commit, got.clr, got.marker,
                                 got.ev, got.snap);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("run stopped at the cycle limit with %0d words outstanding",
                     status_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : main
        int      home_list  [NUM_PHASES];
        int      alarm_list [NUM_PHASES];
        int      n;
        int      waited;
        bit      ignored;
        t_word   w;
        t_status st;

        home_list  = '{0, 3, 0, 3, 1, 2};
        alarm_list = '{2, 3, 0, 1, 3, 2};

        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.req_type     = REQ_KEY;
        req_if.key_code     = KEY_NONE;
        req_if.field_select = FLD_SEC;
        req_if.field_value  = BCD_ZERO;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = ADDR_HOME;
        pwdata              = '0;
        cycles              = 0;
        errors              = 0;
        checked             = 0;
        key_cnt             = 0;
        load_cnt            = 0;
        cfg_cnt             = 0;
        tx_idle             = 1'b1;
        rx_idle             = 1'b1;
        hold_ask            = 1'b0;

        led_q      = 1'b0;
        tset_q     = 1'b0;
        aset_q     = 1'b0;
        ptr_q      = FLD_SEC;
        page_q     = '0;
        home_page  = HOME_MODE_RST;
        alarm_page = ALARM_MODE_RST;
        for (int i = 0; i < NUM_FLDS; i++) begin
            clock_f[i] = BCD_ZERO;
            wake_f[i]  = BCD_ZERO;
        end

        // Directed walk at the reset modes: seconds and year loaded to their
        // maximum, then steps across the seconds, day and year wraps.
        add_row(REQ_KEY, KEY_NONE, FLD_SEC, BCD_ZERO, 1'b1, quiet_status(BCD_ZERO, '0));
        add_row(REQ_LOAD_TIME, KEY_NONE, FLD_SEC, BCD_MAX_MIN, 1'b1,
                quiet_status(BCD_MAX_MIN, 56'h59));
        add_row(REQ_LOAD_TIME, KEY_NONE, FLD_YEAR, BCD_MAX_YEAR, 1'b1,
                quiet_status(BCD_MAX_MIN, 56'h9900_0000_0000_59));
        add_row(REQ_LOAD_TIME, KEY_LAST, SEL_NONE, 8'hFF, 1'b1,
                quiet_status(BCD_MAX_MIN, 56'h9900_0000_0000_59));
        add_row(REQ_UNUSED, KEY_LAST, SEL_NONE, 8'hFF, 1'b1,
                quiet_status(BCD_MAX_MIN, 56'h9900_0000_0000_59));
        add_row(REQ_LOAD_ALARM, KEY_NONE, FLD_DAY, BCD_MAX_DAY, 1'b0, NO_EXP);
        st        = quiet_status(BCD_MAX_MIN, 56'h9900_0000_0000_59);
        st.led    = 1'b1;
        st.tset   = 1'b1;
        st.commit = 1'b1;
        add_row(REQ_KEY, KEY_SET, FLD_SEC, BCD_ZERO, 1'b1, st);
        add_row(REQ_KEY, KEY_UP, FLD_SEC, BCD_ZERO, 1'b0, NO_EXP);
        add_row(REQ_KEY, KEY_DOWN, FLD_SEC, BCD_ZERO, 1'b0, NO_EXP);
        repeat (3) add_row(REQ_KEY, KEY_NEXT, FLD_SEC, BCD_ZERO, 1'b0, NO_EXP);
        add_row(REQ_KEY, KEY_DOWN, FLD_SEC, BCD_ZERO, 1'b0, NO_EXP);
        add_row(REQ_KEY, KEY_UP, FLD_SEC, BCD_ZERO, 1'b0, NO_EXP);
        repeat (3) add_row(REQ_KEY, KEY_NEXT, FLD_SEC, BCD_ZERO, 1'b0, NO_EXP);
        add_row(REQ_KEY, KEY_UP, FLD_SEC, BCD_ZERO, 1'b0, NO_EXP);
        add_row(REQ_KEY, KEY_NEXT, FLD_SEC, BCD_ZERO, 1'b0, NO_EXP);
        add_row(REQ_KEY, KEY_AUX9 + 4'd3, FLD_SEC, BCD_ZERO, 1'b0, NO_EXP);
        add_row(REQ_KEY, KEY_ALARM, FLD_SEC, BCD_ZERO, 1'b0, NO_EXP);
        repeat (2) add_row(REQ_KEY, KEY_MODE, FLD_SEC, BCD_ZERO, 1'b0, NO_EXP);
        add_row(REQ_KEY, KEY_ALARM, FLD_SEC, BCD_ZERO, 1'b0, NO_EXP);
        add_row(REQ_KEY, KEY_UP, FLD_SEC, BCD_ZERO, 1'b0, NO_EXP);
        repeat (2) add_row(REQ_KEY, KEY_MODE, FLD_SEC, BCD_ZERO, 1'b0, NO_EXP);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_tab[i]) send_word(stim_tab[i].w, stim_tab[i].typed, stim_tab[i].exp);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            apb_write(ADDR_HOME, MODE_W'(home_list[p]));
            apb_write(ADDR_ALARM, MODE_W'(alarm_list[p]));
            // One phase runs back to back on both sides.
            tx_idle = (p != 3);
            rx_idle = (p != 3);
            n = 0;
            while (n < PHASE_WORDS) begin
                if (p == 1 && n == 40) hold_ask = 1'b1;
                if (p == 2 && n == PHASE_WORDS / 2) wait_idle();
                w = random_word();
                ignored = (w.req == REQ_UNUSED)
                       || (w.req != REQ_KEY && w.sel >= NUM_FLDS)
                       || (w.req == REQ_KEY && (w.key == KEY_NONE || w.key > KEY_AUX9
                           || (w.key == KEY_ALARM && page_q != alarm_page)));
                send_word(w, 1'b0, NO_EXP);
                if (!ignored) n++;
            end
            wait_idle();
        end

        req_if.valid <= 1'b0;
        waited = 0;
        while (status_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (status_q.size() != 0) begin
            $display("%0d expected words never arrived", status_q.size());
            errors += status_q.size();
        end

        $display("covered %0d key presses and %0d field loads over %0d register writes",
                 key_cnt, load_cnt, cfg_cnt);
        $display("%0d result words compared, %0d mismatches", checked, errors);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
